// ===== hdl/wheel_command_safety_encoder_unit_defines.svh =====
// assertion macros used by the port level checker of the wheel command encoder
`ifndef WHEEL_COMMAND_SAFETY_ENCODER_UNIT_DEFINES_SVH
`define WHEEL_COMMAND_SAFETY_ENCODER_UNIT_DEFINES_SVH

// checked on every rising edge of clk once reset is released
`define WCSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge of clk, reset included
`define WCSE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/wcse_pkg.sv =====
// shared types and constants of the wheel command safety encoder
`default_nettype none

package wcse_pkg;

    localparam int VALUE_WIDTH_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int LIMIT_WIDTH = 15;
    localparam int WORD_WIDTH  = 16;
    localparam int OUT_WIDTH   = 72;

    // register reset values
    localparam logic        MODE_RESET        = 1'b0;
    localparam logic [14:0] SPEED_LIMIT_RESET = 15'd12211;
    localparam logic [14:0] WINDOW_RESET      = 15'd2406;
    localparam logic [7:0]  LOSS_LIMIT_RESET  = 8'd30;

    // rpm to rad/s (pi/30, q.24) and rad/s to rpm*10 (300/pi, q.16)
    localparam int RPM_TO_RAD_Q24      = 1756906;
    localparam int RPM_TO_RAD_BITS     = 21;
    localparam int RPM_TO_RAD_SHIFT    = 24;
    localparam int RAD_TO_RPMX10_Q16   = 6258227;
    localparam int RAD_TO_RPMX10_BITS  = 23;
    localparam int RAD_TO_RPMX10_SHIFT = 16;

    // speed plus steer frame scaling
    localparam int SPEED_MAX    = 300;
    localparam int STEER_MAX    = 90;
    localparam int STEER_SCALE  = 10;
    localparam int STEER_OFFSET = 1000;

    localparam logic [7:0] FRAME_TAG = 8'h01;

    // pipeline depth of one wheel lane, accept to word register
    localparam int LANE_STAGES = 6;

    typedef enum logic [7:0] {
        CFG_COMMAND_MODE      = 8'd0,
        CFG_WHEEL_SPEED_LIMIT = 8'd1,
        CFG_FEEDBACK_WINDOW   = 8'd2,
        CFG_LOSS_LIMIT        = 8'd3
    } cfg_index_t;

    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } operation_t;

    // per-tick control that travels beside the wheel lanes
    typedef struct packed {
        logic        stop;
        logic        go;
        logic        stopped;
        logic        timeout;
        logic        clipped;
        logic        mode;
        logic [15:0] steer_speed_word;
        logic [15:0] steer_angle_word;
    } tick_t;

endpackage

`default_nettype wire

// ===== hdl/wcse_lane.sv =====
// one wheel lane: speed limit clamp, feedback window and rpm word conversion
`default_nettype none

module wcse_lane
    import wcse_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          adv,
    input  wire logic signed [VALUE_WIDTH-1:0] target,
    input  wire logic signed [VALUE_WIDTH-1:0] feedback,
    input  wire logic                          window_en,
    input  wire logic [LIMIT_WIDTH-1:0]        speed_limit,
    input  wire logic [LIMIT_WIDTH-1:0]        window,
    output logic                               clip,
    output logic [WORD_WIDTH-1:0]              word
);

    localparam int W   = VALUE_WIDTH;
    localparam int PW1 = W + RPM_TO_RAD_BITS + 1;
    localparam int PW2 = W + 1 + RAD_TO_RPMX10_BITS + 1;
    localparam int SH2 = RAD_TO_RPMX10_SHIFT + FRACTION_BITS;

    localparam logic signed [PW1-1:0] K1 = PW1'(RPM_TO_RAD_Q24);
    localparam logic signed [PW2-1:0] K2 = PW2'(RAD_TO_RPMX10_Q16);
    localparam logic signed [PW1-1:0] HALF1 = PW1'(1) <<< (RPM_TO_RAD_SHIFT - 1);
    localparam logic signed [PW2-1:0] HALF2 = PW2'(1) <<< (SH2 - 1);
    localparam logic signed [PW2-1:0] WMAX = PW2'(32767);
    localparam logic signed [PW2-1:0] WMIN = -WMAX - PW2'(1);

    logic signed [W-1:0]   lim;
    logic signed [W-1:0]   clamped;

    logic signed [W-1:0]   tgt1_reg;
    logic signed [W-1:0]   fb1_reg;
    logic                  en1_reg;
    logic signed [PW1-1:0] prod2_reg;
    logic signed [W-1:0]   tgt2_reg;
    logic                  en2_reg;
    logic signed [W-1:0]   lf3_reg;
    logic signed [W-1:0]   tgt3_reg;
    logic                  en3_reg;
    logic signed [W:0]     tgt4_reg;
    logic signed [PW2-1:0] prod5_reg;
    logic [WORD_WIDTH-1:0] word6_reg;

    logic signed [PW1-1:0] sum3;
    logic signed [PW1-1:0] shift3;
    logic signed [W:0]     lf_ext;
    logic signed [W:0]     win_ext;
    logic signed [W:0]     hi4;
    logic signed [W:0]     lo4;
    logic signed [W:0]     t4;
    logic signed [PW2-1:0] sum6;
    logic signed [PW2-1:0] q6;
    logic [WORD_WIDTH-1:0] word6_next;

    // symmetric speed limit at accept time
    always_comb
    begin
        lim = signed'({{(W - LIMIT_WIDTH){1'b0}}, speed_limit});
        clip = 1'b0;
        clamped = target;
        if (target > lim)
        begin
            clamped = lim;
            clip = 1'b1;
        end
        else if (target < -lim)
        begin
            clamped = -lim;
            clip = 1'b1;
        end
    end

    // round to nearest, ties away from zero: a negative value drops the half by one
    always_comb
    begin
        sum3 = prod2_reg + HALF1 - PW1'(prod2_reg[PW1-1]);
        shift3 = sum3 >>> RPM_TO_RAD_SHIFT;
    end

    always_comb
    begin
        lf_ext = (W + 1)'(lf3_reg);
        win_ext = signed'({{(W + 1 - LIMIT_WIDTH){1'b0}}, window});
        hi4 = lf_ext + win_ext;
        lo4 = lf_ext - win_ext;
        t4 = (W + 1)'(tgt3_reg);
        if (en3_reg)
        begin
            if (t4 > hi4)
                t4 = hi4;
            if (t4 < lo4)
                t4 = lo4;
        end
    end

    always_comb
    begin
        sum6 = prod5_reg + HALF2 - PW2'(prod5_reg[PW2-1]);
        q6 = sum6 >>> SH2;
        if (q6 > WMAX)
            word6_next = 16'h7FFF;
        else if (q6 < WMIN)
            word6_next = 16'h8000;
        else
            word6_next = q6[WORD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tgt1_reg  <= clamped;
            fb1_reg   <= feedback;
            en1_reg   <= window_en;
            prod2_reg <= PW1'(fb1_reg) * K1;
            tgt2_reg  <= tgt1_reg;
            en2_reg   <= en1_reg;
            lf3_reg   <= shift3[W-1:0];
            tgt3_reg  <= tgt2_reg;
            en3_reg   <= en2_reg;
            tgt4_reg  <= t4;
            prod5_reg <= PW2'(tgt4_reg) * K2;
            word6_reg <= word6_next;
        end
    end

    assign word = word6_reg;

endmodule

`default_nettype wire

// ===== hdl/wcse_merge.sv =====
// merges the two wheel words with the tick control into the frame register
`default_nettype none

module wcse_merge
    import wcse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire tick_t                 info,
    input  wire logic [WORD_WIDTH-1:0] left_word,
    input  wire logic [WORD_WIDTH-1:0] right_word,
    output logic                       adv,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_WIDTH-1:0]       m_axis_tdata
);

    logic                  out_valid_reg;
    logic [OUT_WIDTH-1:0]  out_data_reg;
    logic [OUT_WIDTH-1:0]  out_data_next;
    logic [WORD_WIDTH-1:0] w2;
    logic [WORD_WIDTH-1:0] w4;

    // the whole pipeline moves while the frame register is empty or draining
    assign adv = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (info.stopped)
        begin
            w2 = '0;
            w4 = '0;
        end
        else if (info.mode)
        begin
            w2 = info.steer_speed_word;
            w4 = info.steer_angle_word;
        end
        else
        begin
            w2 = left_word;
            w4 = right_word;
        end
        out_data_next = {6'b0, info.timeout, info.clipped,
                         8'h00, FRAME_TAG, w4, w2,
                         7'b0, info.go, 7'b0, info.stop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/wheel_command_safety_encoder_unit.sv =====
// top level of the wheel command safety encoder
`default_nettype none

// Command items update the stored drive state and produce no output; each tick
// item produces one 8-byte wheel command frame plus clipped and timeout flags.
// One item is taken every cycle while the frame register is not held. A frame reaches
// the master side after its tick is accepted through the speed clamp, the
// two wheel lanes (feedback multiply, rounding, window clamp, rpm multiply,
// rounding and saturation) and the frame register. When the frame register is
// held by the downstream side the whole pipeline holds and s_axis_tready drops.
// Configuration writes are always taken (cfg_ready is tied high) and should be
// made only while no tick is in flight.

module wheel_command_safety_encoder_unit
    import wcse_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // drive_enable, emergency_brake, park_request, left_command, right_command,
    // left_feedback_rpm, right_feedback_rpm, feedback_valid, zero fill
    input  wire logic [((4 * VALUE_WIDTH + 4 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation
    input  wire logic                                       s_axis_tuser,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // payload, was_clipped, timed_out, zero fill
    output logic [OUT_WIDTH-1:0]                            m_axis_tdata,
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [7:0]                                 cfg_index,
    input  wire logic [15:0]                                cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int SW = VALUE_WIDTH + FRACTION_BITS + 5;

    localparam logic signed [SW-1:0] HALF      = SW'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [SW-1:0] SPD_MAX   = SW'(SPEED_MAX) <<< FRACTION_BITS;
    localparam logic signed [SW-1:0] STR_MAX   = SW'(STEER_MAX) <<< FRACTION_BITS;
    localparam logic signed [SW-1:0] STR_OFS   = SW'(STEER_OFFSET) <<< FRACTION_BITS;
    localparam logic signed [SW-1:0] STR_SCALE = SW'(STEER_SCALE);

    logic                   mode_reg;
    logic [LIMIT_WIDTH-1:0] speed_limit_reg;
    logic [LIMIT_WIDTH-1:0] window_reg;
    logic [7:0]             loss_limit_reg;

    logic [7:0]             loss_reg;
    logic [7:0]             loss_next;
    logic                   stop_reg;
    logic                   stop_next;
    logic                   go_reg;
    logic                   go_next;
    logic signed [W-1:0]    left_tgt_reg;
    logic signed [W-1:0]    left_tgt_next;
    logic signed [W-1:0]    right_tgt_reg;
    logic signed [W-1:0]    right_tgt_next;

    logic                   adv;
    logic                   accept;
    logic                   cfg_accept;
    logic                   op_tick;
    logic                   drive_enable;
    logic                   emergency_brake;
    logic                   park_request;
    logic signed [W-1:0]    left_command;
    logic signed [W-1:0]    right_command;
    logic signed [W-1:0]    left_feedback_rpm;
    logic signed [W-1:0]    right_feedback_rpm;
    logic                   feedback_valid;

    logic [7:0]             loss_inc;
    logic                   timeout;
    logic                   left_clip;
    logic                   right_clip;
    logic                   window_en;
    logic signed [SW-1:0]   spd;
    logic signed [SW-1:0]   str;
    logic signed [SW-1:0]   spd_sum;
    logic signed [SW-1:0]   str_sum;
    tick_t                  tick_info;

    logic [LANE_STAGES-1:0] pipe_valid_reg;
    tick_t                  pipe_info_reg [LANE_STAGES];
    logic [WORD_WIDTH-1:0]  left_word;
    logic [WORD_WIDTH-1:0]  right_word;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_axis_tready = adv;

    assign op_tick            = (operation_t'(s_axis_tuser) == OP_TICK);
    assign drive_enable       = s_axis_tdata[0];
    assign emergency_brake    = s_axis_tdata[1];
    assign park_request       = s_axis_tdata[2];
    assign left_command       = s_axis_tdata[3 +: W];
    assign right_command      = s_axis_tdata[3 + W +: W];
    assign left_feedback_rpm  = s_axis_tdata[3 + 2 * W +: W];
    assign right_feedback_rpm = s_axis_tdata[3 + 3 * W +: W];
    assign feedback_valid     = s_axis_tdata[3 + 4 * W];

    // loss count saturates at all ones
    assign loss_inc = (loss_reg == 8'hFF) ? loss_reg : loss_reg + 8'd1;
    assign timeout  = loss_inc > loss_limit_reg;

    always_comb
    begin
        loss_next      = loss_reg;
        stop_next      = stop_reg;
        go_next        = go_reg;
        left_tgt_next  = left_tgt_reg;
        right_tgt_next = right_tgt_reg;
        if (accept && !op_tick)
        begin
            loss_next = '0;
            if (!drive_enable || emergency_brake || park_request)
            begin
                stop_next      = 1'b1;
                go_next        = 1'b0;
                left_tgt_next  = '0;
                right_tgt_next = '0;
            end
            else
            begin
                stop_next      = 1'b0;
                go_next        = 1'b1;
                left_tgt_next  = left_command;
                right_tgt_next = right_command;
            end
        end
        else if (accept)
        begin
            loss_next = loss_inc;
            if (timeout)
            begin
                stop_next = 1'b1;
                go_next   = 1'b0;
            end
        end
    end

    // speed plus steer words come from the raw targets, no wheel clamps
    always_comb
    begin
        spd = SW'(left_tgt_reg);
        if (spd > SPD_MAX)
            spd = SPD_MAX;
        if (spd < SW'(0))
            spd = SW'(0);
        str = SW'(right_tgt_reg);
        if (str > STR_MAX)
            str = STR_MAX;
        if (str < -STR_MAX)
            str = -STR_MAX;
        spd_sum = (spd + HALF) >>> FRACTION_BITS;
        str_sum = (str * STR_SCALE + STR_OFS + HALF) >>> FRACTION_BITS;
    end

    assign window_en = !mode_reg && feedback_valid;

    always_comb
    begin
        tick_info.stop             = stop_next;
        tick_info.go               = go_next;
        tick_info.stopped          = stop_next || !go_next;
        tick_info.timeout          = timeout;
        tick_info.clipped          = !mode_reg && (left_clip || right_clip);
        tick_info.mode             = mode_reg;
        tick_info.steer_speed_word = spd_sum[WORD_WIDTH-1:0];
        tick_info.steer_angle_word = str_sum[WORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
            window_reg      <= WINDOW_RESET;
            loss_limit_reg  <= LOSS_LIMIT_RESET;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                CFG_COMMAND_MODE:      mode_reg        <= cfg_data[0];
                CFG_WHEEL_SPEED_LIMIT: speed_limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
                CFG_FEEDBACK_WINDOW:   window_reg      <= cfg_data[LIMIT_WIDTH-1:0];
                CFG_LOSS_LIMIT:        loss_limit_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_reg       <= '0;
            stop_reg       <= 1'b1;
            go_reg         <= 1'b0;
            left_tgt_reg   <= '0;
            right_tgt_reg  <= '0;
            pipe_valid_reg <= '0;
        end
        else
        begin
            loss_reg      <= loss_next;
            stop_reg      <= stop_next;
            go_reg        <= go_next;
            left_tgt_reg  <= left_tgt_next;
            right_tgt_reg <= right_tgt_next;
            if (adv)
                pipe_valid_reg <= {pipe_valid_reg[LANE_STAGES-2:0], accept && op_tick};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_info_reg[0] <= tick_info;
            for (int i = 1; i < LANE_STAGES; i++)
                pipe_info_reg[i] <= pipe_info_reg[i-1];
        end
    end

    wcse_lane #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_left (
        .clk         (clk),
        .adv         (adv),
        .target      (left_tgt_reg),
        .feedback    (left_feedback_rpm),
        .window_en   (window_en),
        .speed_limit (speed_limit_reg),
        .window      (window_reg),
        .clip        (left_clip),
        .word        (left_word)
    );

    wcse_lane #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_right (
        .clk         (clk),
        .adv         (adv),
        .target      (right_tgt_reg),
        .feedback    (right_feedback_rpm),
        .window_en   (window_en),
        .speed_limit (speed_limit_reg),
        .window      (window_reg),
        .clip        (right_clip),
        .word        (right_word)
    );

    wcse_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pipe_valid_reg[LANE_STAGES-1]),
        .info          (pipe_info_reg[LANE_STAGES-1]),
        .left_word     (left_word),
        .right_word    (right_word),
        .adv           (adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/wcse_checker.sv =====
// port level checks of the wheel command safety encoder and their bind
`default_nettype none

`include "wheel_command_safety_encoder_unit_defines.svh"

module wcse_checker
    import wcse_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [OUT_WIDTH-1:0] m_axis_tdata
);

    // a held frame does not change until its transfer
    `WCSE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "frame changed while stalled")

    // input side only stalls while a frame waits downstream
    `WCSE_ASSERT(a_in_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")

    // stop and go always disagree, trailer bytes are fixed
    `WCSE_ASSERT(a_frame_shape, m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[8]) && (m_axis_tdata[55:48] == FRAME_TAG) && (m_axis_tdata[63:56] == 8'h00), "malformed frame")

    // a timeout frame carries stop and zero words
    `WCSE_ASSERT(a_timeout_stop, m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[0] && (m_axis_tdata[47:16] == 32'h0), "timeout frame not stopped")

endmodule

bind wheel_command_safety_encoder_unit wcse_checker u_wcse_checker (.*);

`default_nettype wire
